>>> hw/rtl/eight_bit_alu_with_flags_assert.svh
// Assertion macros for the eight-bit ALU.
// A_IMP:  when ante holds, cons holds in the same cycle.
// A_NEXT: when ante holds, cons holds in the next cycle.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_ASSERT_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define A_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define A_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define A_IMP(lbl, clk, rstn, ante, cons, msg)
`define A_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> hw/rtl/eba_pkg.sv
`default_nettype none

package eba_pkg;

    localparam int KIND_W  = 5;
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 3;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [KIND_W-1:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_ADD16 = 5'd4,
        OP_INC   = 5'd5,
        OP_DEC   = 5'd6,
        OP_INC16 = 5'd7,
        OP_DEC16 = 5'd8,
        OP_AND   = 5'd9,
        OP_OR    = 5'd10,
        OP_XOR   = 5'd11,
        OP_CP    = 5'd12,
        OP_BIT   = 5'd13,
        OP_RLCA  = 5'd14,
        OP_RRCA  = 5'd15,
        OP_RLA   = 5'd16,
        OP_RRA   = 5'd17,
        OP_RL    = 5'd18,
        OP_RR    = 5'd19
    } kind_t;

    typedef struct packed {
        logic z;
        logic n;
        logic h;
        logic c;
    } flags_t;

    typedef struct packed {
        logic [INDEX_W-1:0] bit_index;
        logic [WORD_W-1:0]  operand_b;
        logic [WORD_W-1:0]  operand_a;
        logic [KIND_W-1:0]  kind;
    } item_t;

endpackage

`default_nettype wire

>>> hw/rtl/eight_bit_alu_with_flags.sv
`default_nettype none

// Eight-bit ALU with Z/N/H/C flags. One operation per transfer, one result per
// operation, accepted every cycle while m_axis_tready stays high: an input register
// feeds combinational ALU logic that loads the result register and the flag register
// together, so each item sees the flags left by the one before it. Each item passes
// the input register and then the result register before its result is presented;
// throughput is one item per cycle while m_axis_tready stays high. Flags clear on
// reset. Unused operation codes pass operand_a and keep the flags.
`include "eight_bit_alu_with_flags_assert.svh"

module eight_bit_alu_with_flags
    import eba_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // kind[4:0], operand_a[20:5], operand_b[36:21], bit_index[39:37]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // value[15:0], zero_flag[16], subtract_flag[17], half_carry_flag[18],
    // carry_flag[19], zero pad[23:20]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

    logic              in_valid_reg;
    item_t             item_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] value_reg;
    flags_t            flags_reg;

    logic              advance;
    logic [WORD_W-1:0] value_next;
    flags_t            flags_next;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                flags_reg     <= flags_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            item_reg <= item_t'(s_axis_tdata);
        end
        if (advance) begin
            value_reg <= value_next;
        end
    end

    logic [BYTE_W-1:0] a8;
    logic [BYTE_W-1:0] b8;
    logic              cin;
    logic              ci;
    logic [BYTE_W:0]   sum9;
    logic [4:0]        nib5;
    logic [BYTE_W:0]   dif9;
    logic [4:0]        nibd5;
    logic [WORD_W:0]   sum17;
    logic [12:0]       sum13;
    logic [BYTE_W-1:0] res8;
    kind_t             kind;

    always_comb begin
        kind  = kind_t'(item_reg.kind);
        a8    = item_reg.operand_a[BYTE_W-1:0];
        b8    = item_reg.operand_b[BYTE_W-1:0];
        cin   = flags_reg.c;
        ci    = ((kind == OP_ADC) || (kind == OP_SBC)) ? cin : 1'b0;
        sum9  = {1'b0, a8} + {1'b0, b8} + {8'd0, ci};
        nib5  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, ci};
        dif9  = {1'b0, a8} - {1'b0, b8} - {8'd0, ci};
        nibd5 = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, ci};
        sum17 = {1'b0, item_reg.operand_a} + {1'b0, item_reg.operand_b};
        sum13 = {1'b0, item_reg.operand_a[11:0]} + {1'b0, item_reg.operand_b[11:0]};
        res8  = '0;

        value_next = item_reg.operand_a;
        flags_next = flags_reg;

        case (kind)
            OP_ADD, OP_ADC: begin
                res8       = sum9[BYTE_W-1:0];
                value_next = {8'd0, res8};
                flags_next = '{z: (res8 == '0), n: 1'b0, h: nib5[4], c: sum9[BYTE_W]};
            end
            OP_SUB, OP_SBC, OP_CP: begin
                res8       = dif9[BYTE_W-1:0];
                value_next = (kind == OP_CP) ? item_reg.operand_a : {8'd0, res8};
                flags_next = '{z: (res8 == '0), n: 1'b1, h: nibd5[4], c: dif9[BYTE_W]};
            end
            OP_ADD16: begin
                value_next = sum17[WORD_W-1:0];
                flags_next = '{z: flags_reg.z, n: 1'b0, h: sum13[12], c: sum17[WORD_W]};
            end
            OP_INC: begin
                res8       = a8 + 8'd1;
                value_next = {8'd0, res8};
                flags_next = '{z: (res8 == '0), n: 1'b0, h: (a8[3:0] == 4'hF), c: cin};
            end
            OP_DEC: begin
                res8       = a8 - 8'd1;
                value_next = {8'd0, res8};
                flags_next = '{z: (res8 == '0), n: 1'b1, h: (a8[3:0] == 4'h0), c: cin};
            end
            OP_INC16: begin
                value_next = item_reg.operand_a + 16'd1;
            end
            OP_DEC16: begin
                value_next = item_reg.operand_a - 16'd1;
            end
            OP_AND: begin
                res8       = a8 & b8;
                value_next = {8'd0, res8};
                flags_next = '{z: (res8 == '0), n: 1'b0, h: 1'b1, c: 1'b0};
            end
            OP_OR: begin
                res8       = a8 | b8;
                value_next = {8'd0, res8};
                flags_next = '{z: (res8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_XOR: begin
                res8       = a8 ^ b8;
                value_next = {8'd0, res8};
                flags_next = '{z: (res8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
            end
            OP_BIT: begin
                flags_next = '{z: !b8[item_reg.bit_index], n: 1'b0, h: 1'b1, c: cin};
            end
            OP_RLCA: begin
                res8       = {a8[6:0], a8[7]};
                value_next = {8'd0, res8};
                flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a8[7]};
            end
            OP_RRCA: begin
                res8       = {a8[0], a8[7:1]};
                value_next = {8'd0, res8};
                flags_next = '{z: 1'b0, n: 1'b0, h: 1'b0, c: a8[0]};
            end
            OP_RLA, OP_RL: begin
                res8       = {a8[6:0], cin};
                value_next = {8'd0, res8};
                flags_next = '{z: (kind == OP_RL) && (res8 == '0), n: 1'b0, h: 1'b0,
                               c: a8[7]};
            end
            OP_RRA, OP_RR: begin
                res8       = {cin, a8[7:1]};
                value_next = {8'd0, res8};
                flags_next = '{z: (kind == OP_RR) && (res8 == '0), n: 1'b0, h: 1'b0,
                               c: a8[0]};
            end
            default: begin
                value_next = item_reg.operand_a;
                flags_next = flags_reg;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, flags_reg.c, flags_reg.h, flags_reg.n, flags_reg.z,
                            value_reg};

    // flags move only with a result
    `A_NEXT(a_flags_hold, aclk, aresetn, !advance, $stable(flags_reg),
            "flags changed without a result transfer")
    `A_NEXT(a_result_loaded, aclk, aresetn, advance, out_valid_reg,
            "computed item did not reach the result register")
    `A_IMP(a_flags_match, aclk, aresetn, out_valid_reg,
           m_axis_tdata[19:16] == {flags_reg.c, flags_reg.h, flags_reg.n, flags_reg.z},
           "presented flags differ from flag register")
    `A_IMP(a_ready_when_empty, aclk, aresetn, !in_valid_reg, s_axis_tready,
           "input stage empty but not ready")

endmodule

`default_nettype wire

>>> tb/sv/tb_eight_bit_alu_with_flags.sv
`default_nettype none

module tb_eight_bit_alu_with_flags;
    import eba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 4;
    localparam int RANDOM_ITEMS = 1300;
    localparam int QUIET_FIRST = 400;
    localparam int QUIET_LAST = 700;
    localparam int IDLE_PCT = 24;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 5'd20;
    localparam logic [KIND_W-1:0] KIND_MAX = 5'd31;

    // value[15:0], zero_flag[16], subtract_flag[17], half_carry_flag[18], carry_flag[19]
    typedef struct packed {
        logic [3:0]        pad;
        logic              carry_flag;
        logic              half_carry_flag;
        logic              subtract_flag;
        logic              zero_flag;
        logic [WORD_W-1:0] value;
    } alu_result_t;

    class alu_flag_scoreboard;
        flags_t      flags;
        alu_result_t awaited_results[$];
        int          checked;
        int          errors;

        function new();
            flags = '0;
            checked = 0;
            errors = 0;
        endfunction

        function flags_t pack_flags(logic z, logic n, logic h, logic c);
            flags_t f;
            f.z = z;
            f.n = n;
            f.h = h;
            f.c = c;
            return f;
        endfunction

        function alu_result_t apply_operation(item_t it);
            int a, b, wa, wb, ci, s;
            logic [7:0] a8, r8;
            flags_t nf;
            alu_result_t res;
            wa = it.operand_a;
            wb = it.operand_b;
            a = wa & 'hFF;
            b = wb & 'hFF;
            a8 = it.operand_a[7:0];
            ci = 0;
            nf = flags;
            res = '0;
            res.value = it.operand_a;
            case (it.kind)
                OP_ADD, OP_ADC: begin
                    if (it.kind == OP_ADC) ci = flags.c;
                    s = a + b + ci;
                    res.value = 16'(s & 'hFF);
                    nf = pack_flags((s & 'hFF) == 0, 1'b0,
                                    (a & 'hF) + (b & 'hF) + ci > 'hF, s > 'hFF);
                end
                OP_SUB, OP_SBC, OP_CP: begin
                    if (it.kind == OP_SBC) ci = flags.c;
                    s = (a - b - ci) & 'hFF;
                    nf = pack_flags(s == 0, 1'b1, (a & 'hF) < (b & 'hF) + ci, a < b + ci);
                    if (it.kind != OP_CP) res.value = 16'(s);
                end
                OP_ADD16: begin
                    s = wa + wb;
                    res.value = 16'(s & 'hFFFF);
                    nf = pack_flags(flags.z, 1'b0,
                                    (wa & 'hFFF) + (wb & 'hFFF) > 'hFFF, s > 'hFFFF);
                end
                OP_INC: begin
                    r8 = a8 + 8'd1;
                    res.value = {8'h00, r8};
                    nf = pack_flags(r8 == 8'h00, 1'b0, a8[3:0] == 4'hF, flags.c);
                end
                OP_DEC: begin
                    r8 = a8 - 8'd1;
                    res.value = {8'h00, r8};
                    nf = pack_flags(r8 == 8'h00, 1'b1, a8[3:0] == 4'h0, flags.c);
                end
                OP_INC16: res.value = it.operand_a + 16'd1;
                OP_DEC16: res.value = it.operand_a - 16'd1;
                OP_AND, OP_OR, OP_XOR: begin
                    if (it.kind == OP_AND) r8 = a8 & it.operand_b[7:0];
                    else if (it.kind == OP_OR) r8 = a8 | it.operand_b[7:0];
                    else r8 = a8 ^ it.operand_b[7:0];
                    res.value = {8'h00, r8};
                    nf = pack_flags(r8 == 8'h00, 1'b0, it.kind == OP_AND, 1'b0);
                end
                OP_BIT:
                    nf = pack_flags(!it.operand_b[it.bit_index], 1'b0, 1'b1, flags.c);
                OP_RLCA: begin
                    res.value = {8'h00, a8[6:0], a8[7]};
                    nf = pack_flags(1'b0, 1'b0, 1'b0, a8[7]);
                end
                OP_RRCA: begin
                    res.value = {8'h00, a8[0], a8[7:1]};
                    nf = pack_flags(1'b0, 1'b0, 1'b0, a8[0]);
                end
                OP_RLA, OP_RL: begin
                    r8 = {a8[6:0], flags.c};
                    res.value = {8'h00, r8};
                    nf = pack_flags(it.kind == OP_RL && r8 == 8'h00, 1'b0, 1'b0, a8[7]);
                end
                OP_RRA, OP_RR: begin
                    r8 = {flags.c, a8[7:1]};
                    res.value = {8'h00, r8};
                    nf = pack_flags(it.kind == OP_RR && r8 == 8'h00, 1'b0, 1'b0, a8[0]);
                end
                default: ;
            endcase
            flags = nf;
            res.zero_flag = nf.z;
            res.subtract_flag = nf.n;
            res.half_carry_flag = nf.h;
            res.carry_flag = nf.c;
            return res;
        endfunction

        function void note_operation(item_t it);
            awaited_results.push_back(apply_operation(it));
        endfunction

        function void compare_field(string name, int expected_val, int actual_val);
            if (expected_val != actual_val) begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, expected_val, actual_val);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            alu_result_t got, want;
            got = word;
            if (awaited_results.size() == 0) begin
                $error("result with nothing outstanding: tdata 0x%0h", word);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            compare_field("value", want.value, got.value);
            compare_field("zero_flag", want.zero_flag, got.zero_flag);
            compare_field("subtract_flag", want.subtract_flag, got.subtract_flag);
            compare_field("half_carry_flag", want.half_carry_flag, got.half_carry_flag);
            compare_field("carry_flag", want.carry_flag, got.carry_flag);
            compare_field("pad", want.pad, got.pad);
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // kind[4:0], operand_a[20:5], operand_b[36:21], bit_index[39:37]
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // value[15:0], zero_flag[16], subtract_flag[17], half_carry_flag[18],
    // carry_flag[19], zero pad[23:20]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    alu_flag_scoreboard book = new();
    logic quiet;
    int   cycle_count;
    int   sent_count;
    int   unused_count;

    eight_bit_alu_with_flags i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    always @(negedge aclk) begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input item_t it);
        if (!quiet) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_axis_tvalid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= it;
        do @(posedge aclk); while (!s_axis_tready);
        book.note_operation(it);
        sent_count++;
        if (it.kind >= KIND_UNUSED_LO) unused_count++;
        @(negedge aclk);
    endtask

    task automatic send_op(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] a,
                           input logic [WORD_W-1:0] b, input logic [INDEX_W-1:0] idx);
        item_t it;
        it.kind = kind;
        it.operand_a = a;
        it.operand_b = b;
        it.bit_index = idx;
        send_item(it);
    endtask

    function automatic logic [WORD_W-1:0] pick_operand();
        logic [WORD_W-1:0] w;
        w = WORD_W'($urandom);
        case ($urandom_range(0, 9))
            0: w = 16'h0000;
            1: w = 16'hFFFF;
            2: w[7:0] = 8'h00;
            3: w[7:0] = 8'hFF;
            4: w[3:0] = 4'hF;
            5: w[3:0] = 4'h0;
            6: w[11:0] = 12'hFFF;
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        item_t it;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        quiet = 1'b0;
        cycle_count = 0;
        sent_count = 0;
        unused_count = 0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: extremes, carry-in, half borrows, flag keeping, rotates
        send_op(OP_ADD,   16'hFFFF, 16'h0001, 3'd0);
        send_op(OP_ADC,   16'h000F, 16'h0000, 3'd0);
        send_op(OP_SUB,   16'h0010, 16'h0001, 3'd0);
        send_op(OP_SUB,   16'h0000, 16'h0001, 3'd0);
        send_op(OP_SBC,   16'h0000, 16'hFFFF, 3'd0);
        send_op(OP_ADC,   16'h00FF, 16'h00FF, 3'd0);
        send_op(OP_DEC,   16'h0010, 16'h0000, 3'd0);
        send_op(OP_DEC,   16'hFF01, 16'h0000, 3'd0);
        send_op(OP_INC,   16'h00FF, 16'h0000, 3'd0);
        send_op(OP_ADD16, 16'hFFFF, 16'h0001, 3'd0);
        send_op(OP_ADD16, 16'h0FFF, 16'h0001, 3'd0);
        send_op(OP_INC16, 16'hFFFF, 16'h0000, 3'd0);
        send_op(OP_DEC16, 16'h0000, 16'hFFFF, 3'd0);
        send_op(OP_AND,   16'hFFF0, 16'h000F, 3'd0);
        send_op(OP_OR,    16'hFF00, 16'hFF00, 3'd0);
        send_op(OP_XOR,   16'h00FF, 16'hFFFF, 3'd0);
        send_op(OP_CP,    16'h0042, 16'h0042, 3'd0);
        send_op(OP_BIT,   16'h1234, 16'h0080, 3'd7);
        send_op(OP_BIT,   16'hFFFF, 16'hFFFE, 3'd0);
        send_op(OP_RLCA,  16'hFF80, 16'h0000, 3'd0);
        send_op(OP_RRCA,  16'h0001, 16'h0000, 3'd0);
        send_op(OP_RLA,   16'h0080, 16'h0000, 3'd0);
        send_op(OP_RRA,   16'h0000, 16'h0000, 3'd0);
        send_op(OP_RL,    16'h0080, 16'h0000, 3'd0);
        send_op(OP_RR,    16'h0001, 16'h0000, 3'd0);
        send_op(KIND_UNUSED_LO, 16'hFFFF, 16'hFFFF, 3'd7);
        send_op(KIND_MAX, 16'h8001, 16'h0000, 3'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (i >= QUIET_FIRST) && (i < QUIET_LAST);
            if ($urandom_range(0, 99) < 8) begin
                it.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_MAX));
            end else begin
                it.kind = KIND_W'($urandom_range(0, OP_RR));
            end
            it.operand_a = pick_operand();
            it.operand_b = ($urandom_range(0, 9) == 0) ? it.operand_a : pick_operand();
            it.bit_index = INDEX_W'($urandom_range(0, 7));
            send_item(it);
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (book.awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d operations covering all 20 opcodes, %0d of them with unused codes,",
                 sent_count, unused_count);
        $display("checked %0d results under random stalls on both channels.", book.checked);
        if (book.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> eight_bit_alu_with_flags.f
+incdir+hw/rtl
hw/rtl/eba_pkg.sv
hw/rtl/eight_bit_alu_with_flags.sv
tb/sv/tb_eight_bit_alu_with_flags.sv
